FILE: src/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAP_BYTES   = 1024;
    localparam int MAP_AW      = 10;
    localparam int POS_W       = 13;
    localparam int QUEUE_CAP   = 1024;
    localparam int QUEUE_DEPTH = QUEUE_CAP + 7;
    localparam int QPTR_W      = 11;
    localparam int BLOCK_W     = 17;
    localparam int BASE_W      = 16;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_LOAD  = 3'd2;
    localparam logic [2:0] OP_NOP   = 3'd3;
    localparam logic [2:0] OP_BAD   = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [POS_W-1:0] pos;
        logic [7:0]       value;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_out;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_stat;

    typedef struct packed {
        logic [BLOCK_W-1:0] number;
        logic [1:0]         status;
    } t_result;

endpackage

FILE: src/bfa_front.sv
`timescale 1ns / 1ps

module bfa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [1:0]                  i_command,
    input  logic [bfa_pkg::BLOCK_W-1:0] i_block,
    input  logic [bfa_pkg::MAP_AW-1:0]  i_byte_index,
    input  logic [7:0]                  i_byte_value,
    input  logic [bfa_pkg::BASE_W-1:0]  i_base,
    input  bfa_pkg::t_back_stat         i_stat,
    output bfa_pkg::t_front_out         o_front
);
    import bfa_pkg::*;

    t_item            r_q [2];
    logic             r_rp;
    logic             r_wp;
    logic [1:0]       r_cnt;
    t_item            cls;
    logic [BLOCK_W:0] diff;
    logic             acc;

    always_comb begin
        diff = {1'b0, i_block} - {2'b0, i_base};
        cls.pos   = diff[POS_W-1:0];
        cls.value = i_byte_value;
        unique case (i_command)
            CMD_ALLOC: cls.op = OP_ALLOC;
            CMD_FREE: begin
                if (diff[BLOCK_W:POS_W] != '0) begin
                    cls.op = OP_BAD;
                end else begin
                    cls.op = OP_FREE;
                end
            end
            CMD_LOAD: begin
                cls.op  = OP_LOAD;
                cls.pos = {{(POS_W-MAP_AW){1'b0}}, i_byte_index};
            end
            default: cls.op = OP_NOP;
        endcase
    end

    assign o_full = (r_cnt == 2'd2) || i_stat.clearing;
    assign acc = i_push && !o_full;
    assign o_front.valid = (r_cnt != 2'd0);
    assign o_front.item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= !r_wp;
            end
            if (i_stat.take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_stat.take};
        end
    end

endmodule

FILE: src/bfa_back.sv
`timescale 1ns / 1ps

module bfa_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bfa_pkg::BASE_W-1:0] i_base,
    input  bfa_pkg::t_front_out        i_front,
    output bfa_pkg::t_back_stat        o_stat,
    input  logic                       i_res_space,
    output logic                       o_res_push,
    output bfa_pkg::t_result           o_res
);
    import bfa_pkg::*;

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_BIT = 4'd3;
    localparam logic [3:0] S_AFTER    = 4'd4;
    localparam logic [3:0] S_POP_A    = 4'd5;
    localparam logic [3:0] S_POP_B    = 4'd6;
    localparam logic [3:0] S_POP_C    = 4'd7;
    localparam logic [3:0] S_FREE_A   = 4'd8;
    localparam logic [3:0] S_FREE_B   = 4'd9;

    localparam logic [QPTR_W-1:0] QCAP    = QPTR_W'(QUEUE_CAP);
    localparam logic [QPTR_W-1:0] QDEPTH  = QPTR_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] QLAST   = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [MAP_AW-1:0] MLAST   = MAP_AW'(MAP_BYTES - 1);
    localparam logic [QPTR_W-1:0] SLAST   = QPTR_W'(MAP_BYTES - 1);

    logic [7:0]        mem_map [MAP_BYTES];
    logic [POS_W-1:0]  mem_q [QUEUE_DEPTH];

    logic [3:0]        r_state, n_state;
    logic [MAP_AW-1:0] r_cursor, n_cursor;
    logic [QPTR_W-1:0] r_steps, n_steps;
    logic [2:0]        r_bit, n_bit;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_cnt, n_cnt;
    logic [MAP_AW-1:0] r_clr, n_clr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_map_q;
    logic [POS_W-1:0]  r_q_q;

    logic              map_we;
    logic [MAP_AW-1:0] map_wa;
    logic [MAP_AW-1:0] map_ra;
    logic [7:0]        map_wd;
    logic              q_we;
    logic [POS_W-1:0]  q_wd;
    logic [7:0]        mask;

    assign mask = 8'(1) << r_pos[2:0];

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_steps  = r_steps;
        n_bit    = r_bit;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_pos    = r_pos;
        map_we   = 1'b0;
        map_wa   = r_pos[POS_W-1:3];
        map_wd   = r_map_q;
        map_ra   = r_cursor;
        q_we     = 1'b0;
        q_wd     = r_pos;
        o_stat.take     = 1'b0;
        o_stat.clearing = (r_state == S_CLR);
        o_res_push  = 1'b0;
        o_res.number = '0;
        o_res.status = ST_OK;
        unique case (r_state)
            S_CLR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                map_wd = 8'd0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == MLAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_front.valid && i_res_space) begin
                    o_stat.take = 1'b1;
                    n_pos  = i_front.item.pos;
                    priority case (i_front.item.op)
                        OP_ALLOC: begin
                            n_steps = '0;
                            n_bit   = '0;
                            n_state = (r_cnt == '0) ? S_SCAN_RD : S_POP_A;
                        end
                        OP_FREE: n_state = S_FREE_A;
                        OP_LOAD: begin
                            map_we = 1'b1;
                            map_wa = i_front.item.pos[MAP_AW-1:0];
                            map_wd = i_front.item.value;
                            o_res_push = 1'b1;
                        end
                        OP_BAD: begin
                            o_res_push = 1'b1;
                            o_res.status = ST_BAD;
                        end
                        default: o_res_push = 1'b1;
                    endcase
                end
            end
            S_SCAN_RD: n_state = S_SCAN_BIT;
            S_SCAN_BIT: begin
                if (!r_map_q[r_bit] && (r_cnt < QDEPTH)) begin
                    q_we  = 1'b1;
                    q_wd  = {r_cursor, r_bit};
                    n_wr  = (r_wr == QLAST) ? '0 : r_wr + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
                n_bit = r_bit + 1'b1;
                if (r_bit == 3'd7) begin
                    n_cursor = (r_cursor == MLAST) ? '0 : r_cursor + 1'b1;
                    n_steps  = r_steps + 1'b1;
                    if ((n_cnt >= QCAP) || (r_steps == SLAST)) begin
                        n_state = S_AFTER;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_AFTER: begin
                if (r_cnt == '0) begin
                    o_res_push = 1'b1;
                    o_res.status = ST_FULL;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_POP_A;
                end
            end
            S_POP_A: n_state = S_POP_B;
            S_POP_B: begin
                map_ra  = r_q_q[POS_W-1:3];
                n_pos   = r_q_q;
                n_state = S_POP_C;
            end
            S_POP_C: begin
                map_ra = r_pos[POS_W-1:3];
                map_we = 1'b1;
                map_wd = r_map_q | mask;
                n_rd   = (r_rd == QLAST) ? '0 : r_rd + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                o_res_push = 1'b1;
                o_res.number = {1'b0, i_base} + {{(BLOCK_W-POS_W){1'b0}}, r_pos};
                n_state = S_IDLE;
            end
            S_FREE_A: begin
                map_ra  = r_pos[POS_W-1:3];
                n_state = S_FREE_B;
            end
            S_FREE_B: begin
                map_ra = r_pos[POS_W-1:3];
                o_res_push = 1'b1;
                if ((r_map_q & mask) == 8'd0) begin
                    o_res.status = ST_BAD;
                end else begin
                    map_we = 1'b1;
                    map_wd = r_map_q & ~mask;
                    if (r_cnt < QDEPTH) begin
                        q_we  = 1'b1;
                        n_wr  = (r_wr == QLAST) ? '0 : r_wr + 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        r_map_q <= mem_map[map_ra];
        if (q_we) begin
            mem_q[r_wr] <= q_wd;
        end
        r_q_q <= mem_q[r_rd];
    end

    always_ff @(posedge i_clk) begin
        r_bit  <= n_bit;
        r_pos  <= n_pos;
        r_steps <= n_steps;
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cursor <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_cnt    <= '0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_cnt    <= n_cnt;
            r_clr    <= n_clr;
        end
    end

endmodule

FILE: src/bitmap_free_block_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// command   in         i_push / o_full  i_command, i_block, i_byte_index, i_byte_value
// result    out        o_empty / i_pop  o_block_number, o_status
// config    in         i_cfg_we         i_cfg_data (base_block)
// A load or an invalid command is answered from idle; a free reads, then rewrites its map byte; an
// allocate pops the free queue and sets the map bit, after a bit-by-bit map scan if it is empty.
// After reset a clearing pass writes all 1024 map bytes, one a cycle, with o_full high.
// Up to two commands and two results are buffered, so each side stalls on its own.

module bitmap_free_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [1:0]                  i_command,
    input  logic [bfa_pkg::BLOCK_W-1:0] i_block,
    input  logic [bfa_pkg::MAP_AW-1:0]  i_byte_index,
    input  logic [7:0]                  i_byte_value,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [bfa_pkg::BLOCK_W-1:0] o_block_number,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::BASE_W-1:0]  i_cfg_data
);
    import bfa_pkg::*;

    logic [BASE_W-1:0] r_base;
    t_front_out        front;
    t_back_stat        stat;
    logic              res_push;
    t_result           res;
    t_result           r_ob [2];
    logic              r_orp;
    logic              r_owp;
    logic [1:0]        r_ocnt;
    logic              pop_ok;

    bfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_command    (i_command),
        .i_block      (i_block),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_base       (r_base),
        .i_stat       (stat),
        .o_front      (front)
    );

    bfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_front     (front),
        .o_stat      (stat),
        .i_res_space (r_ocnt != 2'd2),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    assign o_empty = (r_ocnt == 2'd0);
    assign pop_ok = i_pop && !o_empty;
    assign o_block_number = r_ob[r_orp].number;
    assign o_status = r_ob[r_orp].status;

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_ob[r_owp] <= res;
        end
        if (!i_rst_n) begin
            r_base <= '0;
            r_orp  <= 1'b0;
            r_owp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (res_push) begin
                r_owp <= !r_owp;
            end
            if (pop_ok) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, res_push} - {1'b0, pop_ok};
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bfa_pkg::*;

    localparam int MAP_BITS   = MAP_BYTES * 8;
    localparam int IDLE_LIMIT = 40000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [1:0]         i_command;
    logic [BLOCK_W-1:0] i_block;
    logic [MAP_AW-1:0]  i_byte_index;
    logic [7:0]         i_byte_value;
    logic               o_empty;
    logic               i_pop;
    logic [BLOCK_W-1:0] o_block_number;
    logic [1:0]         o_status;
    logic               i_cfg_we;
    logic [BASE_W-1:0]  i_cfg_data;

    bitmap_free_block_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_command(i_command), .i_block(i_block), .i_byte_index(i_byte_index),
        .i_byte_value(i_byte_value), .o_empty(o_empty), .i_pop(i_pop),
        .o_block_number(o_block_number), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow copy of the allocator state.
    logic [7:0]       map_shadow [MAP_BYTES];
    logic [POS_W-1:0] fifo_shadow [QUEUE_DEPTH];
    int               fifo_rd, fifo_wr, fifo_cnt, cursor;
    logic [BASE_W-1:0] base_shadow;

    t_result   pending_results[$];
    int        used_positions[$];
    int        mismatches;
    int        idle_cycles;
    bit        hold_off_req;
    bit        transfer_seen;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void shadow_queue(input int pos);
        fifo_shadow[fifo_wr] = pos[POS_W-1:0];
        fifo_wr = (fifo_wr + 1) % QUEUE_DEPTH;
        fifo_cnt++;
    endfunction

    function automatic void shadow_rescan();
        logic [7:0] bits;
        for (int s = 0; s < MAP_BYTES; s++) begin
            bits = map_shadow[cursor];
            for (int b = 0; b < 8; b++) begin
                if (!bits[b] && fifo_cnt < QUEUE_DEPTH)
                    shadow_queue(cursor * 8 + b);
            end
            cursor = (cursor + 1) % MAP_BYTES;
            if (fifo_cnt >= QUEUE_CAP)
                break;
        end
    endfunction

    function automatic t_result predict_allocator(input logic [1:0] cmd,
            input logic [BLOCK_W-1:0] blk, input logic [MAP_AW-1:0] idx,
            input logic [7:0] val);
        t_result r;
        int pos;
        r.number = '0;
        r.status = ST_OK;
        if (cmd == CMD_ALLOC) begin
            if (fifo_cnt == 0)
                shadow_rescan();
            if (fifo_cnt == 0) begin
                r.status = ST_FULL;
            end else begin
                pos = int'(fifo_shadow[fifo_rd]) % MAP_BITS;
                fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH;
                fifo_cnt--;
                map_shadow[pos / 8][pos % 8] = 1'b1;
                r.number = BLOCK_W'(int'(base_shadow) + pos);
                used_positions.push_back(pos);
            end
        end else if (cmd == CMD_FREE) begin
            if (int'(blk) < int'(base_shadow) || int'(blk) - int'(base_shadow) >= MAP_BITS) begin
                r.status = ST_BAD;
            end else begin
                pos = int'(blk) - int'(base_shadow);
                if (!map_shadow[pos / 8][pos % 8]) begin
                    r.status = ST_BAD;
                end else begin
                    map_shadow[pos / 8][pos % 8] = 1'b0;
                    if (fifo_cnt < QUEUE_DEPTH)
                        shadow_queue(pos);
                end
            end
        end else if (cmd == CMD_LOAD) begin
            map_shadow[idx] = val;
        end
        return r;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [BLOCK_W-1:0] blk,
            input logic [MAP_AW-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_push       <= 1'b1;
        i_command    <= cmd;
        i_block      <= blk;
        i_byte_index <= idx;
        i_byte_value <= val;
        do
            @(posedge i_clk);
        while (o_full);
        pending_results.push_back(predict_allocator(cmd, blk, idx, val));
    endtask

    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        base_shadow = value;
    endtask

    task automatic send_free_pos(input int pos);
        send_item(CMD_FREE, BLOCK_W'(int'(base_shadow) + pos), '0, '0);
    endtask

    task automatic test_basic_commands();
        send_item(CMD_ALLOC, '0, '0, '0);
        send_item(CMD_ALLOC, '1, '1, '1);
        send_free_pos(0);
        send_free_pos(0);
        send_item(CMD_FREE, '1, '0, '0);
        send_item(CMD_LOAD, '0, MAP_AW'(MAP_BYTES - 1), 8'hff);
        send_item(CMD_LOAD, '0, '0, 8'h00);
        send_item(2'd3, '1, '1, '1);
        send_free_pos(MAP_BITS - 1);
        send_free_pos(MAP_BITS - 1);
    endtask

    task automatic test_full_queue_free();
        send_item(CMD_LOAD, '0, 10'd500, 8'hff);
        send_item(CMD_LOAD, '0, 10'd501, 8'hff);
        for (int i = 0; i < 16; i++)
            send_free_pos(500 * 8 + i);
    endtask

    task automatic test_range_edges();
        write_base(16'd1000);
        send_item(CMD_FREE, 17'd999, '0, '0);
        send_item(CMD_FREE, BLOCK_W'(1000 + MAP_BITS), '0, '0);
        send_item(CMD_ALLOC, '0, '0, '0);
        write_base('1);
        send_item(CMD_ALLOC, '0, '0, '0);
        send_item(CMD_FREE, '0, '0, '0);
    endtask

    task automatic test_out_of_space();
        for (int i = 0; i < MAP_BYTES; i++)
            send_item(CMD_LOAD, '0, MAP_AW'(i), 8'hff);
        while (fifo_cnt > 0)
            send_item(CMD_ALLOC, '0, '0, '0);
        send_item(CMD_ALLOC, '0, '0, '0);
        send_item(CMD_ALLOC, '0, '0, '0);
        send_free_pos(77);
        send_item(CMD_ALLOC, '0, '0, '0);
        for (int i = 0; i < 128; i++)
            send_item(CMD_LOAD, '0, MAP_AW'(i), 8'h00);
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(i % 2 ? CMD_FREE : CMD_ALLOC, BLOCK_W'($urandom), '0, '0);
    endtask

    task automatic test_random_traffic(input int count);
        int sel, k;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                send_item(CMD_ALLOC, BLOCK_W'($urandom), MAP_AW'($urandom), 8'($urandom));
            end else if (sel < 65 && used_positions.size() != 0) begin
                k = $urandom_range(0, used_positions.size() - 1);
                send_free_pos(used_positions[k]);
                used_positions.delete(k);
            end else if (sel < 75) begin
                send_item(CMD_FREE, BLOCK_W'($urandom), MAP_AW'($urandom), 8'($urandom));
            end else if (sel < 80) begin
                send_free_pos($urandom_range(0, MAP_BITS - 1));
            end else if (sel < 95) begin
                send_item(CMD_LOAD, BLOCK_W'($urandom), MAP_AW'($urandom),
                          8'($urandom) & 8'($urandom));
            end else begin
                send_item(2'd3, BLOCK_W'($urandom), MAP_AW'($urandom), 8'($urandom));
            end
            sender_gap();
        end
    endtask

    // Receiver: pop pattern is redrawn periodically at random, plus one requested long stall.
    initial begin
        int mode, tick, hold;
        mode = 0;
        tick = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && hold == 0) begin
                hold = 400;
                hold_off_req = 1'b0;
            end
            if (tick % 64 == 0)
                mode = $urandom_range(0, 2);
            tick++;
            if (hold > 0) begin
                hold--;
                i_pop <= 1'b0;
            end else if (mode == 0) begin
                i_pop <= 1'b1;
            end else if (mode == 1) begin
                i_pop <= 1'($urandom);
            end else begin
                i_pop <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            transfer_seen = (i_push && !o_full) || (i_pop && !o_empty);
            if (i_rst_n && i_pop && !o_empty) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result", o_status, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_block_number !== want.number)
                        report("block_number", o_block_number, want.number);
                    if (o_status !== want.status)
                        report("status", o_status, want.status);
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            #1;
            if (transfer_seen)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_push       = 1'b0;
        i_pop        = 1'b0;
        i_command    = '0;
        i_block      = '0;
        i_byte_index = '0;
        i_byte_value = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        mismatches   = 0;
        hold_off_req = 1'b0;
        transfer_seen = 1'b0;
        for (int i = 0; i < MAP_BYTES; i++)
            map_shadow[i] = '0;
        fifo_rd = 0;
        fifo_wr = 0;
        fifo_cnt = 0;
        cursor = 0;
        base_shadow = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_out_of_space();
        test_basic_commands();
        test_full_queue_free();
        test_range_edges();
        write_base('0);
        test_backpressure();
        test_random_traffic(95);
        write_base('1);
        test_random_traffic(95);
        write_base(BASE_W'($urandom));
        test_random_traffic(95);
        write_base(16'd1);
        test_random_traffic(95);

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
